@@ sv/brf_pkg.sv @@
`default_nettype none
package brf_pkg;

   localparam int RAM_DEPTH = 256;
   localparam int ADDR_W    = $clog2(RAM_DEPTH);
   localparam int RING_W    = ADDR_W + 1;
   localparam int STEP_W    = $clog2(ADDR_W);

   localparam logic [RING_W-1:0] RING_MIN   = RING_W'(2);
   localparam logic [RING_W-1:0] RING_MAX   = RING_W'(RAM_DEPTH);
   localparam logic [RING_W-1:0] RING_RESET = RING_W'(256);

   typedef enum logic [2:0] {
      ACT_PUSH    = 3'd0,
      ACT_POP     = 3'd1,
      ACT_DISCARD = 3'd2,
      ACT_PEEK    = 3'd3,
      ACT_POKE    = 3'd4,
      ACT_CLEAR   = 3'd5,
      ACT_QUERY   = 3'd6
   } action_type;

   localparam logic [1:0] ST_OK    = 2'd0;
   localparam logic [1:0] ST_FULL  = 2'd1;
   localparam logic [1:0] ST_SHORT = 2'd2;

   typedef struct packed {
      logic [2:0] action;
      logic [7:0] data_in;
      logic [7:0] offset;
      logic [7:0] byte_count;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic [7:0] fill_level;
      logic [7:0] free_space;
      logic [1:0] status;
   } rsp_type;

   typedef struct packed {
      logic accept;
      logic mod_step;
      logic access;
      logic load_rsp;
   } cmd_type;

   typedef struct packed {
      logic needs_mod;
      logic mod_done;
      logic rsp_free;
   } sts_type;

endpackage
`default_nettype wire

@@ sv/brf_ram.sv @@
`default_nettype none
module brf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     we,
   input  wire logic [$clog2(DEPTH)-1:0] waddr,
   input  wire logic [WIDTH-1:0]         wdata,
   input  wire logic                     re,
   input  wire logic [$clog2(DEPTH)-1:0] raddr,
   output logic      [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      if (re) begin
         rdata <= mem_ff[raddr];
      end
   end

endmodule
`default_nettype wire

@@ sv/brf_ctrl.sv @@
`default_nettype none
module brf_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   input  wire brf_pkg::sts_type sts,
   output brf_pkg::cmd_type      cmd
);
   import brf_pkg::*;

   typedef enum logic [3:0] {
      S_IDLE   = 4'b0001,
      S_MOD    = 4'b0010,
      S_ACCESS = 4'b0100,
      S_RESULT = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      req_ready    = 1'b0;
      unique case (state_ff)
         S_IDLE: begin
            req_ready  = 1'b1;
            cmd.accept = req_valid;
            if (req_valid) begin
               state_in = sts.needs_mod ? S_MOD : S_ACCESS;
            end
         end
         S_MOD: begin
            cmd.mod_step = 1'b1;
            if (sts.mod_done) begin
               state_in = S_ACCESS;
            end
         end
         S_ACCESS: begin
            cmd.access = 1'b1;
            state_in   = S_RESULT;
         end
         S_RESULT: begin
            if (sts.rsp_free) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

@@ sv/brf_dp.sv @@
`default_nettype none
module brf_dp (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire brf_pkg::req_type               req_item,
   input  wire logic                           csr_we,
   input  wire logic [brf_pkg::RING_W-1:0]     csr_wdata,
   input  wire logic                           rsp_ready,
   output logic                                rsp_valid,
   output brf_pkg::rsp_type                    rsp_item,
   input  wire brf_pkg::cmd_type               cmd,
   output brf_pkg::sts_type                    sts
);
   import brf_pkg::*;

   localparam int SHIFT_W = RING_W + ADDR_W - 1;

   logic [RING_W-1:0] ring_ff, ring_in;
   logic [ADDR_W-1:0] head_ff, head_in;
   logic [ADDR_W-1:0] tail_ff, tail_in;
   logic              rsp_valid_ff, rsp_valid_in;

   req_type           item_ff, item_in;
   logic [7:0]        rem_ff, rem_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic [1:0]        status_ff, status_in;
   logic              rd_ok_ff, rd_ok_in;
   rsp_type           rsp_ff, rsp_in;

   logic [RING_W-1:0]  fill9;
   logic [RING_W-1:0]  free9;
   logic [RING_W-1:0]  head_p1;
   logic [RING_W-1:0]  tail_p1;
   logic [RING_W-1:0]  head_pc;
   logic [RING_W-1:0]  head_po;
   logic [ADDR_W-1:0]  pos;
   logic [SHIFT_W-1:0] shifted;
   logic [RING_W-1:0]  clamped;

   logic              ram_we;
   logic [ADDR_W-1:0] ram_waddr;
   logic [7:0]        ram_wdata;
   logic              ram_re;
   logic [ADDR_W-1:0] ram_raddr;
   logic [7:0]        ram_rdata;

   brf_ram #(
      .WIDTH (8),
      .DEPTH (RAM_DEPTH)
   ) u_ram (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .re    (ram_re),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   always_comb begin
      if (tail_ff >= head_ff) begin
         fill9 = {1'b0, tail_ff} - {1'b0, head_ff};
      end else begin
         fill9 = ring_ff + {1'b0, tail_ff} - {1'b0, head_ff};
      end
      free9 = ring_ff - fill9 - RING_W'(1);

      head_p1 = {1'b0, head_ff} + RING_W'(1);
      if (head_p1 >= ring_ff) begin
         head_p1 = '0;
      end
      tail_p1 = {1'b0, tail_ff} + RING_W'(1);
      if (tail_p1 >= ring_ff) begin
         tail_p1 = '0;
      end
      head_pc = {1'b0, head_ff} + {1'b0, item_ff.byte_count};
      if (head_pc >= ring_ff) begin
         head_pc = head_pc - ring_ff;
      end
      head_po = {1'b0, head_ff} + {1'b0, rem_ff};
      if (head_po >= ring_ff) begin
         head_po = head_po - ring_ff;
      end
      pos = head_po[ADDR_W-1:0];

      shifted = SHIFT_W'(ring_ff) << step_ff;

      if (csr_wdata < RING_MIN) begin
         clamped = RING_MIN;
      end else if (csr_wdata > RING_MAX) begin
         clamped = RING_MAX;
      end else begin
         clamped = csr_wdata;
      end
   end

   always_comb begin
      ring_in      = ring_ff;
      head_in      = head_ff;
      tail_in      = tail_ff;
      item_in      = item_ff;
      rem_in       = rem_ff;
      step_in      = step_ff;
      status_in    = status_ff;
      rd_ok_in     = rd_ok_ff;
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff;
      ram_we       = 1'b0;
      ram_waddr    = tail_ff;
      ram_wdata    = item_ff.data_in;
      ram_re       = 1'b0;
      ram_raddr    = head_ff;

      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      if (cmd.accept) begin
         item_in = req_item;
         rem_in  = req_item.offset;
         step_in = '1;
      end

      if (cmd.mod_step) begin
         if (SHIFT_W'(rem_ff) >= shifted) begin
            rem_in = rem_ff - shifted[7:0];
         end
         step_in = step_ff - STEP_W'(1);
      end

      if (cmd.access) begin
         status_in = ST_OK;
         rd_ok_in  = 1'b0;
         case (item_ff.action)
            ACT_PUSH: begin
               if (fill9 + RING_W'(1) >= ring_ff) begin
                  status_in = ST_FULL;
               end else begin
                  ram_we    = 1'b1;
                  ram_waddr = tail_ff;
                  tail_in   = tail_p1[ADDR_W-1:0];
               end
            end
            ACT_POP: begin
               if (fill9 == '0) begin
                  status_in = ST_SHORT;
               end else begin
                  ram_re    = 1'b1;
                  ram_raddr = head_ff;
                  rd_ok_in  = 1'b1;
                  head_in   = head_p1[ADDR_W-1:0];
               end
            end
            ACT_DISCARD: begin
               if ({1'b0, item_ff.byte_count} > fill9) begin
                  status_in = ST_SHORT;
               end else begin
                  head_in = head_pc[ADDR_W-1:0];
               end
            end
            ACT_PEEK: begin
               ram_re    = 1'b1;
               ram_raddr = pos;
               rd_ok_in  = 1'b1;
            end
            ACT_POKE: begin
               ram_we    = 1'b1;
               ram_waddr = pos;
            end
            ACT_CLEAR: begin
               head_in = '0;
               tail_in = '0;
            end
            default: begin
            end
         endcase
      end

      if (cmd.load_rsp) begin
         rsp_in.read_data  = rd_ok_ff ? ram_rdata : 8'd0;
         rsp_in.fill_level = fill9[7:0];
         rsp_in.free_space = free9[7:0];
         rsp_in.status     = status_ff;
         rsp_valid_in      = 1'b1;
      end

      if (csr_we) begin
         ring_in = clamped;
         head_in = '0;
         tail_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ring_ff      <= RING_RESET;
         head_ff      <= '0;
         tail_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ring_ff      <= ring_in;
         head_ff      <= head_in;
         tail_ff      <= tail_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff   <= item_in;
      rem_ff    <= rem_in;
      step_ff   <= step_in;
      status_ff <= status_in;
      rd_ok_ff  <= rd_ok_in;
      rsp_ff    <= rsp_in;
   end

   assign sts.needs_mod = (req_item.action == ACT_PEEK) || (req_item.action == ACT_POKE);
   assign sts.mod_done  = (step_ff == '0);
   assign sts.rsp_free  = !rsp_valid_ff || rsp_ready;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule
`default_nettype wire

@@ sv/byte_ring_fifo_top.sv @@
// Circular byte FIFO with a programmable ring size of 2 to 256 bytes; one
// slot always stays empty, so the usable depth is one less than the ring size.
// Each transfer on the req_ channel carries one action: push, pop, discard,
// peek, poke, clear or query. Each action yields exactly one transfer on the
// rsp_ channel with the byte read, the fill level, the free space and a status.
// The csr_ port writes the ring size; a write also empties the FIFO and must
// only be issued while no action is in flight.
// For push, pop, discard, clear and query the accepted action passes through
// the access and result states. Peek and poke first pass through a modulo state,
// where the offset is reduced modulo the ring size by a shift-subtract unit that
// handles one bit per cycle. The byte store is a single-port-per-direction RAM
// with a registered read, so the byte read in the access state is loaded into
// the result in the result state. The block handles one action at a time and
// takes no new action until the result of the last one is loaded.
// Results sit in an output register; while the receiver stalls, the next
// action can be taken and processed, and the block waits only to load its
// result. Reset empties the FIFO, sets the ring size to 256 and clears the
// result valid; the store contents stay undefined until written.
`default_nettype none
module byte_ring_fifo_top (
   input  wire logic                         clock,
   input  wire logic                         reset,
   input  wire logic                         req_valid,
   output logic                              req_ready,
   input  wire brf_pkg::req_type             req_item,
   output logic                              rsp_valid,
   input  wire logic                         rsp_ready,
   output brf_pkg::rsp_type                  rsp_item,
   input  wire logic                         csr_we,
   input  wire logic [brf_pkg::RING_W-1:0]   csr_wdata
);
   import brf_pkg::*;

   cmd_type cmd;
   sts_type sts;

   brf_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   brf_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_item  (req_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item),
      .cmd       (cmd),
      .sts       (sts)
   );

endmodule
`default_nettype wire

@@ tb/byte_ring_fifo_top_test.sv @@
`timescale 1ns / 100ps
module byte_ring_fifo_top_test;
   import brf_pkg::*;

   localparam logic [2:0] ACT_SPARE = 3'd7;
   localparam int PHASE_COUNT   = 12;
   localparam int PHASE_ITEMS   = 85;
   localparam int SETTLE_CYCLES = 16;
   localparam int QUIET_LIMIT   = 1000;

   localparam logic [RING_W-1:0] RING_SETTINGS [PHASE_COUNT] = '{
      RING_W'(2), RING_W'(3), RING_W'(256), RING_W'(0), RING_W'(17), RING_W'(1),
      RING_W'(511), RING_W'(5), RING_W'(300), RING_W'(64), RING_W'(4), RING_W'(256)
   };

   logic              clock     = 1'b0;
   logic              reset     = 1'b1;
   logic              req_valid = 1'b0;
   logic              req_ready;
   req_type           req_item  = '0;
   logic              rsp_valid;
   logic              rsp_ready = 1'b0;
   rsp_type           rsp_item;
   logic              csr_we    = 1'b0;
   logic [RING_W-1:0] csr_wdata = RING_RESET;

   byte_ring_fifo_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_item  (rsp_item),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   req_type pending_reqs [$];
   rsp_type fifo_answers [$];
   int      issued_total   = 0;
   int      accepted_total = 0;
   int      checked_total  = 0;
   int      mismatch_count = 0;
   int      full_refusals  = 0;
   int      short_refusals = 0;
   int      settings_used  = 0;
   int      quiet_cycles   = 0;
   int      send_gap       = 0;
   int      stall_left     = 0;
   bit      steady         = 1'b0;

   logic [7:0]        ring_bytes [RAM_DEPTH];
   logic [RING_W-1:0] live_cfg   = RING_RESET;
   int                live_front = 0;
   int                live_back  = 0;

   bit                plan_written [RAM_DEPTH];
   logic [RING_W-1:0] plan_cfg   = RING_RESET;
   int                plan_front = 0;
   int                plan_back  = 0;

   function automatic int ring_size_of(logic [RING_W-1:0] cfg);
      if (cfg < RING_MIN) return int'(RING_MIN);
      if (cfg > RING_MAX) return int'(RING_MAX);
      return int'(cfg);
   endfunction

   function automatic int ring_advance(int pos, int by, int size);
      int p;
      p = pos + by % size;
      if (p >= size) p -= size;
      return p;
   endfunction

   function automatic int ring_fill(int front, int back, int size);
      return (back >= front) ? back - front : size + back - front;
   endfunction

   function automatic rsp_type fifo_answer(req_type r);
      rsp_type a;
      int      size;
      int      fill;
      size = ring_size_of(live_cfg);
      if (live_front >= size) live_front = 0;
      if (live_back >= size) live_back = 0;
      fill = ring_fill(live_front, live_back, size);
      a = '0;
      case (r.action)
         ACT_PUSH: begin
            if (fill + 1 >= size) a.status = ST_FULL;
            else begin
               ring_bytes[live_back] = r.data_in;
               live_back = ring_advance(live_back, 1, size);
            end
         end
         ACT_POP: begin
            if (fill == 0) a.status = ST_SHORT;
            else begin
               a.read_data = ring_bytes[live_front];
               live_front = ring_advance(live_front, 1, size);
            end
         end
         ACT_DISCARD: begin
            if (int'(r.byte_count) > fill) a.status = ST_SHORT;
            else live_front = ring_advance(live_front, r.byte_count, size);
         end
         ACT_PEEK: a.read_data = ring_bytes[ring_advance(live_front, r.offset, size)];
         ACT_POKE: ring_bytes[ring_advance(live_front, r.offset, size)] = r.data_in;
         ACT_CLEAR: begin
            live_front = 0;
            live_back = 0;
         end
         default: ;
      endcase
      fill = ring_fill(live_front, live_back, size);
      a.fill_level = fill[7:0];
      a.free_space = 8'(size - fill - 1);
      if (a.status == ST_FULL) full_refusals++;
      else if (a.status == ST_SHORT) short_refusals++;
      return a;
   endfunction

   // The pointers are followed here as items are queued, so that a peek never reads
   // a slot that has never been written; such a peek becomes a poke of that slot.
   function automatic void schedule_action(logic [2:0] act, logic [7:0] data,
                                           logic [7:0] offs, logic [7:0] count);
      req_type r;
      int      size;
      int      fill;
      size = ring_size_of(plan_cfg);
      fill = ring_fill(plan_front, plan_back, size);
      if (act == ACT_PEEK && !plan_written[ring_advance(plan_front, offs, size)])
         act = ACT_POKE;
      case (act)
         ACT_PUSH: begin
            if (fill + 1 < size) begin
               plan_written[plan_back] = 1'b1;
               plan_back = ring_advance(plan_back, 1, size);
            end
         end
         ACT_POP: if (fill > 0) plan_front = ring_advance(plan_front, 1, size);
         ACT_DISCARD: if (int'(count) <= fill) plan_front = ring_advance(plan_front, count, size);
         ACT_POKE: plan_written[ring_advance(plan_front, offs, size)] = 1'b1;
         ACT_CLEAR: begin
            plan_front = 0;
            plan_back = 0;
         end
         default: ;
      endcase
      r.action = act;
      r.data_in = data;
      r.offset = offs;
      r.byte_count = count;
      pending_reqs.push_back(r);
      issued_total++;
   endfunction

   function automatic void schedule_random(int push_pct);
      int         pick;
      int         fill;
      logic [2:0] act;
      logic [7:0] offs;
      logic [7:0] count;
      fill = ring_fill(plan_front, plan_back, ring_size_of(plan_cfg));
      pick = $urandom_range(0, 99);
      if (pick < push_pct) act = ACT_PUSH;
      else if (pick < 70) act = ACT_POP;
      else if (pick < 78) act = ACT_DISCARD;
      else if (pick < 86) act = ACT_PEEK;
      else if (pick < 93) act = ACT_POKE;
      else if (pick < 95) act = ACT_CLEAR;
      else if (pick < 98) act = ACT_QUERY;
      else act = ACT_SPARE;
      if ($urandom_range(0, 3) == 0) offs = 8'($urandom_range(0, 255));
      else offs = 8'($urandom_range(0, fill));
      if ($urandom_range(0, 3) == 0) count = 8'($urandom_range(0, 255));
      else count = 8'($urandom_range(0, (fill < 255) ? fill + 1 : 255));
      schedule_action(act, 8'($urandom_range(0, 255)), offs, count);
   endfunction

   function automatic int idle_length();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 3);
      if (pick < 96) return $urandom_range(4, 9);
      return $urandom_range(20, 60);
   endfunction

   function automatic void report_failure(string what, rsp_type want, rsp_type got);
      mismatch_count++;
      if (mismatch_count <= 10)
         $display("%s at result %0d: expected data %02h fill %0d free %0d status %0d,",
                  what, checked_total, want.read_data, want.fill_level,
                  want.free_space, want.status,
                  " got data %02h fill %0d free %0d status %0d",
                  got.read_data, got.fill_level, got.free_space, got.status);
   endfunction

   function automatic void check_answer(rsp_type got);
      rsp_type want;
      if (fifo_answers.size() == 0) begin
         report_failure("Unexpected transfer", '0, got);
         return;
      end
      want = fifo_answers.pop_front();
      checked_total++;
      if (got.read_data !== want.read_data || got.fill_level !== want.fill_level ||
          got.free_space !== want.free_space || got.status !== want.status)
         report_failure("Mismatch", want, got);
   endfunction

   task automatic wait_drained();
      do @(posedge clock);
      while (accepted_total != issued_total || fifo_answers.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic set_ring_size(logic [RING_W-1:0] value);
      wait_drained();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      live_cfg = value;
      live_front = 0;
      live_back = 0;
      plan_cfg = value;
      plan_front = 0;
      plan_back = 0;
      settings_used++;
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         send_gap = 0;
      end else begin
         if (req_valid && req_ready) begin
            fifo_answers.push_back(fifo_answer(req_item));
            accepted_total++;
         end
         if (!req_valid || req_ready) begin
            if (send_gap > 0) begin
               send_gap--;
               req_valid <= 1'b0;
            end else if (pending_reqs.size() > 0) begin
               req_item <= pending_reqs.pop_front();
               req_valid <= 1'b1;
               send_gap = steady ? 0 : idle_length();
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         stall_left = 0;
      end else begin
         if (rsp_valid && rsp_ready) check_answer(rsp_item);
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            stall_left = steady ? 0 : idle_length();
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= QUIET_LIMIT);
      $display("Some tests failed");
      $finish;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      schedule_action(ACT_QUERY, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_POP, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_DISCARD, 8'h00, 8'h00, 8'h01);
      schedule_action(ACT_DISCARD, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_PUSH, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_PUSH, 8'hFF, 8'h00, 8'h00);
      schedule_action(ACT_PUSH, 8'hA5, 8'h00, 8'h00);
      schedule_action(ACT_POKE, 8'h3C, 8'h01, 8'h00);
      schedule_action(ACT_PEEK, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_PEEK, 8'h00, 8'h01, 8'h00);
      schedule_action(ACT_POP, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_POKE, 8'h77, 8'h05, 8'h00);
      schedule_action(ACT_PEEK, 8'h00, 8'h05, 8'h00);
      schedule_action(ACT_DISCARD, 8'h00, 8'h00, 8'hFF);
      schedule_action(ACT_DISCARD, 8'h00, 8'h00, 8'h02);
      schedule_action(ACT_SPARE, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_POKE, 8'h12, 8'hFF, 8'h00);
      schedule_action(ACT_PEEK, 8'h00, 8'hFF, 8'h00);
      schedule_action(ACT_CLEAR, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_PUSH, 8'hFF, 8'hFF, 8'hFF);
      schedule_action(ACT_PEEK, 8'h00, 8'h00, 8'h00);
      schedule_action(ACT_QUERY, 8'hFF, 8'hFF, 8'hFF);

      for (int i = 0; i < PHASE_COUNT; i++) begin
         set_ring_size(RING_SETTINGS[i]);
         steady = (i % 4 == 3);
         for (int k = 0; k < PHASE_ITEMS; k++) schedule_random((i % 2 == 1) ? 30 : 55);
      end

      wait_drained();
      $display("Checked %0d results from %0d actions over %0d ring size settings.",
               checked_total, accepted_total, settings_used);
      $display("Saw %0d pushes refused as full and %0d pops or discards refused as short.",
               full_refusals, short_refusals);
      if (mismatch_count == 0 && fifo_answers.size() == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule

@@ sim.f @@
sv/brf_pkg.sv
sv/brf_ram.sv
sv/brf_ctrl.sv
sv/brf_dp.sv
sv/byte_ring_fifo_top.sv
tb/byte_ring_fifo_top_test.sv
